>>> rtl/dpb_pkg.sv
// ============================================================================
// dpb_pkg: shared types and constants for the depth pixel back-projection unit
// Holds the register indexes, the divider lane struct and the side-band struct.
// ============================================================================
package dpb_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [2:0] REG_MIN_DEPTH   = 3'd1;
    localparam logic [2:0] REG_MAX_DEPTH   = 3'd2;
    localparam logic [2:0] REG_FOCAL_X     = 3'd3;
    localparam logic [2:0] REG_FOCAL_Y     = 3'd4;
    localparam logic [2:0] REG_CENTRE_X    = 3'd5;
    localparam logic [2:0] REG_CENTRE_Y    = 3'd6;

    // Width of the numerator magnitude handed along the divider chain.
    localparam int NUM_W  = 50;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              zero_div;
        logic [NUM_W-1:0]  rem;
        logic [NUM_W-1:0]  mag;
        logic [15:0]       focal;
    } div_lane_t;

    typedef struct packed {
        logic        point_valid;
        logic [15:0] pos_z;
        logic [23:0] packed_colour;
    } side_t;

endpackage

>>> rtl/dpb_div_cell.sv
// ============================================================================
// dpb_div_cell: one restoring-division cell
// Retires one quotient bit of a 50-bit magnitude per cycle while advance is high and passes on.
// ============================================================================
module dpb_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  dpb_pkg::div_lane_t  lane_in,
    output dpb_pkg::div_lane_t  lane_out
);
    import dpb_pkg::*;

    dpb_pkg::div_lane_t lane_reg;
    logic [NUM_W-1:0]   shifted;
    logic [NUM_W:0]     trial;
    dpb_pkg::div_lane_t lane_next;

    // Shift one numerator bit into the partial remainder and try a subtract.
    always_comb begin
        lane_next = lane_in;
        shifted   = {lane_in.rem[NUM_W-2:0], lane_in.mag[NUM_W-1]};
        trial     = {1'b0, shifted} - {{(NUM_W-16+1){1'b0}}, lane_in.focal};
        lane_next.mag = {lane_in.mag[NUM_W-2:0], 1'b0};
        if (!trial[NUM_W]) begin
            lane_next.rem    = trial[NUM_W-1:0];
            lane_next.mag[0] = 1'b1;
        end else begin
            lane_next.rem = shifted;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else if (advance) begin
            lane_reg.valid <= lane_next.valid;
        end
        if (advance) begin
            lane_reg.neg      <= lane_next.neg;
            lane_reg.zero_div <= lane_next.zero_div;
            lane_reg.rem      <= lane_next.rem;
            lane_reg.mag      <= lane_next.mag;
            lane_reg.focal    <= lane_next.focal;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> rtl/dpb_axis_lane.sv
// ============================================================================
// dpb_axis_lane: one coordinate path
// Forms the magnitude of (16p - c) * z * 16, runs it through a chain of
// divider cells and saturates the signed quotient to 32 bits.
// ============================================================================
module dpb_axis_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               start,
    input  logic [12:0]        pos,
    input  logic [15:0]        centre,
    input  logic [15:0]        focal,
    input  logic [15:0]        depth,
    output logic signed [31:0] coord
);
    import dpb_pkg::*;

    // Stage 1: signed difference in Q.4, registered magnitude and sign.
    logic signed [18:0] diff;
    logic [17:0]        diff_mag_reg;
    logic               neg_reg;
    logic [15:0]        depth_reg;
    logic [15:0]        focal_reg;
    logic               s1_valid_reg;

    assign diff = $signed({2'b00, pos, 4'b0000}) - $signed({3'b000, centre});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= start;
        end
        if (advance) begin
            diff_mag_reg <= diff[18] ? 18'(-diff) : diff[17:0];
            neg_reg      <= diff[18];
            depth_reg    <= depth;
            focal_reg    <= focal;
        end
    end

    // Stage 2: one 18 x 16 multiplier, result scaled by 16 in the cell input.
    logic [33:0] prod;
    assign prod = diff_mag_reg * depth_reg;

    dpb_pkg::div_lane_t chain [0:NUM_W];

    // A zero focal length divides by one instead, so the quotient still tells
    // whether the numerator is zero; the flag then saturates the result.
    always_comb begin
        chain[0].valid    = s1_valid_reg;
        chain[0].neg      = neg_reg;
        chain[0].zero_div = (focal_reg == 16'd0);
        chain[0].rem      = '0;
        chain[0].mag      = {{(NUM_W-38){1'b0}}, prod, 4'b0000};
        chain[0].focal    = (focal_reg == 16'd0) ? 16'd1 : focal_reg;
    end

    // Chain of division cells, one quotient bit each.
    for (genvar i = 0; i < NUM_W; i++) begin : g_cell
        dpb_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .lane_in  (chain[i]),
            .lane_out (chain[i+1])
        );
    end

    // Saturate the quotient to the signed 32-bit range.
    logic [NUM_W-1:0] q;
    logic             nz;
    assign q  = chain[NUM_W].mag;
    assign nz = (chain[0].valid | 1'b1) & (q != '0);

    always_comb begin
        if (chain[NUM_W].zero_div) begin
            if (!nz) coord = 32'sd0;
            else coord = chain[NUM_W].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (chain[NUM_W].neg) begin
            if (q > {{(NUM_W-32){1'b0}}, 32'h8000_0000}) coord = 32'sh8000_0000;
            else coord = 32'(-q);
        end else begin
            if (q > {{(NUM_W-32){1'b0}}, 32'h7FFF_FFFF}) coord = 32'sh7FFF_FFFF;
            else coord = q[31:0];
        end
    end

endmodule

>>> rtl/depth_pixel_backprojection_unit.sv
// ============================================================================
// depth_pixel_backprojection_unit: pinhole depth to point cloud
// Back-projects raster-order depth pixels into 3D points with packed colour.
// ============================================================================
// Path: a pixel passes the input register, which loads at the accepting edge
// itself, then each cell of the 50-cell divider chain and then the output
// register, which presents its point.
// Throughput: one pixel per cycle; the whole chain stalls when the output is
// held. Reset is synchronous, active low; it restores the register defaults
// and clears the column and row counters and all stage valid bits.
module depth_pixel_backprojection_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_frame_start,
    input  logic [15:0]        s_depth_mm,
    input  logic [7:0]         s_red,
    input  logic [7:0]         s_green,
    input  logic [7:0]         s_blue,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_point_valid,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [15:0]        m_pos_z,
    output logic [23:0]        m_packed_colour
);
    import dpb_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = NUM_W + 1;

    // Configuration registers
    logic [12:0] image_width_reg;
    logic [15:0] min_depth_reg, max_depth_reg;
    logic [15:0] focal_x_reg, focal_y_reg, centre_x_reg, centre_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= 13'd640;
            min_depth_reg   <= 16'd200;
            max_depth_reg   <= 16'd3000;
            focal_x_reg     <= 16'd9600;
            focal_y_reg     <= 16'd9600;
            centre_x_reg    <= 16'd5120;
            centre_y_reg    <= 16'd3840;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[12:0];
                REG_MIN_DEPTH:   min_depth_reg   <= cfg_data;
                REG_MAX_DEPTH:   max_depth_reg   <= cfg_data;
                REG_FOCAL_X:     focal_x_reg     <= cfg_data;
                REG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                REG_CENTRE_X:    centre_x_reg    <= cfg_data;
                REG_CENTRE_Y:    centre_y_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the output slot is free or being taken.
    logic advance, accept;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    // Column and row counters
    logic [CW-1:0] col_reg, col_next, u;
    logic [RW-1:0] row_reg, row_next, v;
    logic [CW-1:0] width_eff;

    always_comb begin
        if (image_width_reg == 13'd0 || 32'(image_width_reg) > MAX_WIDTH)
            width_eff = CW'(MAX_WIDTH);
        else
            width_eff = CW'(image_width_reg);
        u = s_frame_start ? '0 : col_reg;
        v = s_frame_start ? '0 : row_reg;
        if ((32'(u) + 32'd1) >= 32'(width_eff)) begin
            col_next = '0;
            row_next = (32'(v) + 32'd1 >= MAX_HEIGHT) ? '0 : RW'(v + 1'b1);
        end else begin
            col_next = CW'(u + 1'b1);
            row_next = v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Range filter and colour travel alongside the divider chain.
    dpb_pkg::side_t side_in;
    dpb_pkg::side_t side_pipe [0:DEPTH-1];
    logic           ok;

    assign ok = s_depth_mm != 16'd0 && s_depth_mm >= min_depth_reg
             && s_depth_mm <= max_depth_reg;

    always_comb begin
        side_in.point_valid   = ok;
        side_in.pos_z         = ok ? s_depth_mm : 16'd0;
        side_in.packed_colour = ok ? {s_red, s_green, s_blue} : 24'd0;
    end

    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[DEPTH-2:0], accept};
        end
        if (advance) begin
            side_pipe[0] <= side_in;
            for (int i = 1; i < DEPTH; i++) side_pipe[i] <= side_pipe[i-1];
        end
    end

    logic signed [31:0] x_coord, y_coord;

    dpb_axis_lane u_lane_x (
        .aclk (aclk), .aresetn (aresetn), .advance (advance), .start (accept),
        .pos (13'(u)), .centre (centre_x_reg), .focal (focal_x_reg),
        .depth (s_depth_mm), .coord (x_coord)
    );

    dpb_axis_lane u_lane_y (
        .aclk (aclk), .aresetn (aresetn), .advance (advance), .start (accept),
        .pos (13'(v)), .centre (centre_y_reg), .focal (focal_y_reg),
        .depth (s_depth_mm), .coord (y_coord)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= vld_reg[DEPTH-1];
        end
        if (advance) begin
            m_point_valid   <= side_pipe[DEPTH-1].point_valid;
            m_pos_z         <= side_pipe[DEPTH-1].pos_z;
            m_packed_colour <= side_pipe[DEPTH-1].packed_colour;
            m_pos_x <= side_pipe[DEPTH-1].point_valid ? x_coord : 32'sd0;
            m_pos_y <= side_pipe[DEPTH-1].point_valid ? y_coord : 32'sd0;
        end
    end

`ifndef SYNTHESIS
    // A held beat must stay valid and keep its x position and depth.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_z))
        else $error("output beat changed while stalled");
    // An invalid point carries zero coordinates.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_point_valid |-> m_pos_x == 0 && m_pos_y == 0 && m_pos_z == 0)
        else $error("invalid point with nonzero fields");
    // Input is not taken while the output is stalled.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");
`endif

endmodule

>>> dv/depth_pixel_backprojection_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// depth_pixel_backprojection_unit_tb: self-checking bench for the unit
// Sends raster-order depth pixels through several camera setups, predicts each
// back-projected point and compares it field by field with the output beat.
// ============================================================================
module depth_pixel_backprojection_unit_tb;
    import dpb_pkg::*;

    localparam int PIX_MAX_WIDTH  = 4096;
    localparam int PIX_MAX_HEIGHT = 4096;
    localparam int DRAIN_CYCLES   = 80;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 250;
    localparam int HOLD_AT_BEAT   = 300;

    typedef struct packed {
        logic        frame_start;
        logic [15:0] depth_mm;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    typedef struct packed {
        logic               point_valid;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        pos_z;
        logic [23:0]        packed_colour;
    } point_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = REG_IMAGE_WIDTH;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_frame_start = 1'b0;
    logic [15:0]        s_depth_mm = '0;
    logic [7:0]         s_red = '0;
    logic [7:0]         s_green = '0;
    logic [7:0]         s_blue = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_point_valid;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic [15:0]        m_pos_z;
    logic [23:0]        m_packed_colour;

    depth_pixel_backprojection_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_frame_start(s_frame_start), .s_depth_mm(s_depth_mm),
        .s_red(s_red), .s_green(s_green), .s_blue(s_blue),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_valid(m_point_valid), .m_pos_x(m_pos_x), .m_pos_y(m_pos_y),
        .m_pos_z(m_pos_z), .m_packed_colour(m_packed_colour)
    );

    // Clock: 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Camera setup and raster position as the unit should hold them.
    logic [12:0] cam_width = 13'd640;
    logic [15:0] cam_min_depth = 16'd200;
    logic [15:0] cam_max_depth = 16'd3000;
    logic [15:0] cam_focal_x = 16'd9600;
    logic [15:0] cam_focal_y = 16'd9600;
    logic [15:0] cam_centre_x = 16'd5120;
    logic [15:0] cam_centre_y = 16'd3840;
    int unsigned raster_col = 0;
    int unsigned raster_row = 0;

    pixel_t pending_pixels[$];
    point_t expected_points[$];
    int     pixels_queued = 0;
    int     pixels_sent = 0;
    int     mismatches = 0;
    int     cycle_count = 0;
    bit     quiet = 1'b0;

    // Back-projection of one coordinate, truncated toward zero, saturated.
    function automatic logic signed [31:0] project_axis(int unsigned pos,
            logic [15:0] centre, logic [15:0] focal, logic [15:0] z);
        longint diff;
        longint num;
        longint q;
        diff = longint'(pos) * 16 - longint'(centre);
        num = diff * longint'(z) * 16;
        if (focal == 0)
            q = (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
        else
            q = num / longint'(focal);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // Point for one pixel; advances the raster position.
    function automatic point_t backproject_pixel(pixel_t px);
        point_t pt;
        int unsigned width;
        pt = '0;
        if (px.frame_start) begin
            raster_col = 0;
            raster_row = 0;
        end
        if (px.depth_mm != 0 && px.depth_mm >= cam_min_depth &&
                px.depth_mm <= cam_max_depth) begin
            pt.point_valid = 1'b1;
            pt.pos_x = project_axis(raster_col, cam_centre_x, cam_focal_x, px.depth_mm);
            pt.pos_y = project_axis(raster_row, cam_centre_y, cam_focal_y, px.depth_mm);
            pt.pos_z = px.depth_mm;
            pt.packed_colour = {px.red, px.green, px.blue};
        end
        width = cam_width;
        if (width == 0 || width > PIX_MAX_WIDTH) width = PIX_MAX_WIDTH;
        if (raster_col + 1 >= width) begin
            raster_col = 0;
            raster_row = (raster_row + 1 >= PIX_MAX_HEIGHT) ? 0 : raster_row + 1;
        end else begin
            raster_col = raster_col + 1;
        end
        return pt;
    endfunction

    // Pixel driver: idles in short bursts, predicts each accepted beat.
    int src_gap = 0;
    always @(posedge aclk) begin
        bit free;
        pixel_t px;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            free = !s_valid;
            if (s_valid && s_ready) begin
                expected_points.push_back(backproject_pixel(
                    {s_frame_start, s_depth_mm, s_red, s_green, s_blue}));
                pixels_sent++;
                free = 1'b1;
            end
            if (free) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 2);
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    px = pending_pixels.pop_front();
                    s_valid <= 1'b1;
                    s_frame_start <= px.frame_start;
                    s_depth_mm <= px.depth_mm;
                    s_red <= px.red;
                    s_green <= px.green;
                    s_blue <= px.blue;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own, once mid-run.
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!hold_done && pixels_sent >= HOLD_AT_BEAT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Point monitor: stalls in short bursts and during the hold-off, and checks every output beat.
    int sink_gap = 0;
    always @(posedge aclk) begin
        point_t want;
        point_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_point_valid, m_pos_x, m_pos_y, m_pos_z, m_packed_colour};
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected point beat: %p", got);
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("point mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= (hold_left == 0);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("depth_pixel_backprojection_unit_tb: done, errors");
            $finish;
        end
    end

    // Register write; cfg_valid stays high for back-to-back writes.
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH: cam_width = value[12:0];
            REG_MIN_DEPTH:   cam_min_depth = value;
            REG_MAX_DEPTH:   cam_max_depth = value;
            REG_FOCAL_X:     cam_focal_x = value;
            REG_FOCAL_Y:     cam_focal_y = value;
            REG_CENTRE_X:    cam_centre_x = value;
            REG_CENTRE_Y:    cam_centre_y = value;
            default: ;
        endcase
    endtask

    task automatic load_camera(logic [15:0] width, logic [15:0] dmin, logic [15:0] dmax,
            logic [15:0] fx, logic [15:0] fy, logic [15:0] cx, logic [15:0] cy);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_MIN_DEPTH, dmin);
        write_reg(REG_MAX_DEPTH, dmax);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTRE_X, cx);
        write_reg(REG_CENTRE_Y, cy);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic queue_pixel(bit fs, logic [15:0] depth, logic [23:0] rgb);
        pending_pixels.push_back({fs, depth, rgb});
        pixels_queued++;
    endtask

    // Mostly depths in range with random colour; some zero, at or just past the range edges, any.
    task automatic queue_random(int count);
        logic [15:0] depth;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) depth = 16'd0;
            else if (pick <= 2) depth = 16'($urandom_range(0, 65535));
            else if (pick == 3) depth = cam_min_depth - 16'($urandom_range(0, 2));
            else if (pick == 4) depth = cam_max_depth + 16'($urandom_range(0, 2));
            else if (cam_min_depth <= cam_max_depth)
                depth = 16'($urandom_range(cam_min_depth, cam_max_depth));
            else depth = 16'($urandom_range(0, 65535));
            queue_pixel($urandom_range(0, 99) == 0, depth, 24'($urandom));
        end
    endtask

    // Wait until every queued pixel has been answered and the pipe is empty.
    task automatic drain();
        do @(posedge aclk);
        while (pixels_sent != pixels_queued || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Power-up setup: range edges, no reading, colour extremes.
        queue_pixel(1'b1, 16'd1000, 24'hFFFFFF);
        queue_pixel(1'b0, 16'd0, 24'hFFFFFF);
        queue_pixel(1'b0, 16'd199, 24'h123456);
        queue_pixel(1'b0, 16'd200, 24'h000000);
        queue_pixel(1'b0, 16'd3000, 24'hFF0000);
        queue_pixel(1'b0, 16'd3001, 24'h00FF00);
        queue_pixel(1'b0, 16'd65535, 24'h0000FF);
        queue_pixel(1'b0, 16'd2999, 24'hA5A5A5);
        queue_pixel(1'b1, 16'd201, 24'h5A5A5A);
        queue_pixel(1'b0, 16'd1500, 24'h808080);
        drain();

        // Full depth range, focal zero and 16, extreme centres.
        load_camera(16'd5, 16'd0, 16'd65535, 16'd0, 16'd16, 16'd65535, 16'd0);
        queue_pixel(1'b1, 16'd65535, 24'hFFFFFF);
        queue_pixel(1'b0, 16'd1, 24'h010101);
        queue_pixel(1'b0, 16'd0, 24'hFFFFFF);
        queue_pixel(1'b0, 16'd65535, 24'h7F7F7F);
        queue_random(120);
        drain();

        // Empty range, width above the maximum.
        load_camera(16'h1FFF, 16'd1000, 16'd500, 16'd65535, 16'd0, 16'd0, 16'd65535);
        queue_random(60);
        drain();

        // One pixel per row, width zero acting as maximum.
        load_camera(16'd1, 16'd1, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0);
        queue_random(80);
        drain();
        load_camera(16'd0, 16'd100, 16'd60000, 16'd300, 16'd200, 16'd32768, 16'd1);
        queue_random(100);
        drain();

        // Shrink the width while the column count lies beyond it.
        load_camera(16'd3, 16'd100, 16'd60000, 16'd300, 16'd200, 16'd32768, 16'd1);
        queue_random(40);
        drain();

        // Random camera setups; the last one runs without idling.
        for (int ph = 0; ph < 6; ph++) begin
            load_camera(16'($urandom_range(1, 700)), 16'($urandom_range(0, 2000)),
                16'($urandom_range(1500, 65535)), 16'($urandom_range(16, 65535)),
                16'($urandom_range(16, 65535)), 16'($urandom), 16'($urandom));
            if (ph == 5) quiet = 1'b1;
            queue_random(90);
            drain();
        end

        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("depth_pixel_backprojection_unit_tb: done, clean");
        end else begin
            $display("depth_pixel_backprojection_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
